// ===== hw/rtl/spgp_pkg.sv =====
// spgp_pkg: shared types and constants for the sphere patch grid point pipeline.
// Used by spgp_isqrt, spgp_divider and sphere_patch_grid_point.
package spgp_pkg;

  localparam int GridSizeDef = 32;

  // raw vector N = 2S*c + a*across + d*down stays below 2^40 over the whole
  // GRID_SIZE range; one sign bit on top
  localparam int NW    = 42;
  localparam int MW    = NW - 1;        // magnitude width
  localparam int RW    = 31;            // normalised magnitude, msb at bit 30
  localparam int SqW   = 64;            // sum of three squares
  localparam int RootW = SqW / 2;
  localparam int FracW = 30;            // Q1.30 output
  localparam int NumW  = RW + FracW + 1;
  localparam int QW    = FracW + 1;
  localparam int OffW  = 12;
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgReverseRows = 8'd0,
    CfgBorderCells = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic        [5:0]  row;
    logic        [5:0]  col;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] center_z;
    logic signed [31:0] across_x;
    logic signed [31:0] across_y;
    logic signed [31:0] across_z;
    logic signed [31:0] down_x;
    logic signed [31:0] down_y;
    logic signed [31:0] down_z;
  } in_t;

  typedef struct packed {
    logic signed [31:0]     point_x;
    logic signed [31:0]     point_y;
    logic signed [31:0]     point_z;
    logic        [OffW-1:0] mesh_offset;
    logic                   zero_length;
  } out_t;

endpackage

// ===== hw/rtl/spgp_isqrt.sv =====
// spgp_isqrt: pipelined integer square root, one result bit per stage.
// Depends on spgp_pkg for widths.
module spgp_isqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [spgp_pkg::SqW-1:0]  x_i,
  output logic [spgp_pkg::RootW-1:0] root_o
);

  localparam int NS = spgp_pkg::RootW;
  localparam int CW = spgp_pkg::SqW + 2;

  logic [spgp_pkg::SqW-1:0]   rem_q  [NS];
  logic [spgp_pkg::RootW-1:0] root_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Bit = NS - 1 - k;
    logic [spgp_pkg::SqW-1:0]   rem_in;
    logic [spgp_pkg::RootW-1:0] root_in;
    logic [CW-1:0]              cand;

    if (k == 0) begin : g_first
      assign rem_in  = x_i;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    // (root + 2^i)^2 - root^2
    assign cand = (CW'(root_in) << (Bit + 1)) + (CW'(1) << (2 * Bit));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (CW'(rem_in) >= cand) begin
          rem_q[k]  <= rem_in - cand[spgp_pkg::SqW-1:0];
          root_q[k] <= root_in | (spgp_pkg::RootW'(1) << Bit);
        end else begin
          rem_q[k]  <= rem_in;
          root_q[k] <= root_in;
        end
      end
    end
  end

  assign root_o = root_q[NS-1];

endmodule

// ===== hw/rtl/spgp_divider.sv =====
// spgp_divider: pipelined restoring divider, one quotient bit per stage.
// Depends on spgp_pkg for widths; quotient must fit QW bits.
module spgp_divider (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [spgp_pkg::NumW-1:0]   num_i,
  input  logic [spgp_pkg::RootW-1:0]  den_i,
  output logic [spgp_pkg::QW-1:0]     quo_o
);

  localparam int NS = spgp_pkg::QW;
  localparam int CW = spgp_pkg::NumW + 1;

  logic [spgp_pkg::NumW-1:0]  rem_q [NS];
  logic [spgp_pkg::RootW-1:0] den_q [NS];
  logic [spgp_pkg::QW-1:0]    quo_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int Bit = NS - 1 - k;
    logic [spgp_pkg::NumW-1:0]  rem_in;
    logic [spgp_pkg::RootW-1:0] den_in;
    logic [spgp_pkg::QW-1:0]    quo_in;
    logic [CW-1:0]              trial;

    if (k == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    assign trial = CW'(den_in) << Bit;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
        if (CW'(rem_in) >= trial) begin
          rem_q[k] <= rem_in - trial[spgp_pkg::NumW-1:0];
          quo_q[k] <= quo_in | (spgp_pkg::QW'(1) << Bit);
        end else begin
          rem_q[k] <= rem_in;
          quo_q[k] <= quo_in;
        end
      end
    end
  end

  assign quo_o = quo_q[NS-1];

endmodule

// ===== hw/rtl/sphere_patch_grid_point.sv =====
// sphere_patch_grid_point: grid point of a planar patch projected onto the unit sphere.
// Sustains one beat per cycle while the skid slot is empty.
// Depth is set by the bit-per-stage square root (32) and the three dividers (31).
// A two-entry output register/skid pair; in_stall_o is a registered skid-full flag.
// rst_ni clears the valid bits, the skid state and both configuration registers.
module sphere_patch_grid_point #(
  parameter int GRID_SIZE = spgp_pkg::GridSizeDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  spgp_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output spgp_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [spgp_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [spgp_pkg::CfgDataW-1:0] cfg_data_i
);

  localparam int AW       = $clog2(GRID_SIZE + 127) + 1;
  localparam int NW       = spgp_pkg::NW;
  localparam int MW       = spgp_pkg::MW;
  localparam int RW       = spgp_pkg::RW;
  localparam int OffW     = spgp_pkg::OffW;
  localparam int PosW     = $clog2(MW);
  localparam int FrontLat = 7;
  localparam int SqrtLat  = spgp_pkg::RootW;
  localparam int DivLat   = spgp_pkg::QW;
  localparam int PipeLat  = FrontLat + SqrtLat + 1 + DivLat;

  typedef struct packed {
    logic [2:0]      neg;
    logic            zero;
    logic [OffW-1:0] offset;
  } side_t;

  typedef struct packed {
    logic [2:0][RW-1:0] r;
    side_t              side;
  } sqrt_side_t;

  // configuration
  logic reverse_rows_q, border_cells_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reverse_rows_q <= 1'b0;
      border_cells_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        spgp_pkg::CfgReverseRows: reverse_rows_q <= cfg_data_i[0];
        spgp_pkg::CfgBorderCells: border_cells_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // whole pipe moves together; it halts only once the skid slot holds a beat
  logic en;
  logic skid_v_q, out_v_q;
  logic [PipeLat-1:0] pipe_v_q;

  assign en         = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_v_q <= '0;
    end else if (en) begin
      pipe_v_q <= {pipe_v_q[PipeLat-2:0], in_valid_i};
    end
  end

  // stage 0: coefficients, products, mesh offset
  logic signed [AW-1:0] col_s, row_s, b_s, a_c, d_c;
  logic signed [31:0]   c_a [3];
  logic signed [31:0]   ac_a [3];
  logic signed [31:0]   dn_a [3];
  logic [OffW-1:0]      g_c, r_c, off_c;

  always_comb begin
    col_s = AW'(in_data_i.col);
    row_s = AW'(in_data_i.row);
    b_s   = AW'(border_cells_q);
    a_c   = ((col_s - b_s) <<< 1) - AW'(GRID_SIZE);
    d_c   = AW'(GRID_SIZE) - ((row_s - b_s) <<< 1);
    c_a[0]  = in_data_i.center_x;
    c_a[1]  = in_data_i.center_y;
    c_a[2]  = in_data_i.center_z;
    ac_a[0] = in_data_i.across_x;
    ac_a[1] = in_data_i.across_y;
    ac_a[2] = in_data_i.across_z;
    dn_a[0] = in_data_i.down_x;
    dn_a[1] = in_data_i.down_y;
    dn_a[2] = in_data_i.down_z;
    g_c   = OffW'(GRID_SIZE + 1) + OffW'({border_cells_q, 1'b0});
    r_c   = reverse_rows_q ? (g_c - OffW'(1) - OffW'(in_data_i.row)) : OffW'(in_data_i.row);
    off_c = OffW'((r_c * g_c + OffW'(in_data_i.col)) * OffW'(3));
  end

  logic signed [NW-1:0] pc_q [3];
  logic signed [NW-1:0] pa_q [3];
  logic signed [NW-1:0] pd_q [3];
  logic [OffW-1:0]      off0_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc_q[i] <= NW'(c_a[i]) * NW'(2 * GRID_SIZE);
        pa_q[i] <= NW'(ac_a[i]) * NW'(a_c);
        pd_q[i] <= NW'(dn_a[i]) * NW'(d_c);
      end
      off0_q <= off_c;
    end
  end

  // stage 1: sum, sign and magnitude
  logic [MW-1:0]   mag1_q [3];
  logic [2:0]      neg1_q;
  logic [OffW-1:0] off1_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        logic signed [NW-1:0] n;
        n = pc_q[i] + pa_q[i] + pd_q[i];
        neg1_q[i] <= n[NW-1];
        mag1_q[i] <= n[NW-1] ? MW'(-n) : MW'(n);
      end
      off1_q <= off0_q;
    end
  end

  // stage 2: largest magnitude
  logic [MW-1:0]   mag2_q [3];
  logic [MW-1:0]   max2_q;
  side_t           side2_q;
  logic [MW-1:0]   max01;

  assign max01 = (mag1_q[0] > mag1_q[1]) ? mag1_q[0] : mag1_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag2_q         <= mag1_q;
      max2_q         <= (max01 > mag1_q[2]) ? max01 : mag1_q[2];
      side2_q.neg    <= neg1_q;
      side2_q.zero   <= (mag1_q[0] == '0) && (mag1_q[1] == '0) && (mag1_q[2] == '0);
      side2_q.offset <= off1_q;
    end
  end

  // stage 3: shift that puts the top bit of the maximum at bit 30
  logic [PosW-1:0] msb_c;

  always_comb begin
    msb_c = '0;
    for (int b = 0; b < MW; b++) begin
      if (max2_q[b]) msb_c = PosW'(b);
    end
  end

  logic [MW-1:0] mag3_q [3];
  logic          right3_q;
  logic [4:0]    amt3_q;
  side_t         side3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mag3_q  <= mag2_q;
      side3_q <= side2_q;
      if (msb_c > PosW'(RW - 1)) begin
        right3_q <= 1'b1;
        amt3_q   <= 5'(msb_c - PosW'(RW - 1));
      end else begin
        right3_q <= 1'b0;
        amt3_q   <= 5'(PosW'(RW - 1) - msb_c);
      end
    end
  end

  // stage 4: normalise
  logic [2:0][RW-1:0] r4_q;
  side_t              side4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r4_q[i] <= right3_q ? RW'(mag3_q[i] >> amt3_q) : RW'(mag3_q[i] << amt3_q);
      end
      side4_q <= side3_q;
    end
  end

  // stage 5: squares
  logic [2*RW-1:0]    sq5_q [3];
  logic [2:0][RW-1:0] r5_q;
  side_t              side5_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq5_q[i] <= (2*RW)'(r4_q[i]) * (2*RW)'(r4_q[i]);
      end
      r5_q    <= r4_q;
      side5_q <= side4_q;
    end
  end

  // stage 6: sum of squares
  logic [spgp_pkg::SqW-1:0] sum6_q;
  sqrt_side_t               sb6_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sum6_q     <= spgp_pkg::SqW'(sq5_q[0]) + spgp_pkg::SqW'(sq5_q[1])
                  + spgp_pkg::SqW'(sq5_q[2]);
      sb6_q.r    <= r5_q;
      sb6_q.side <= side5_q;
    end
  end

  // square root, side data delayed alongside
  logic [spgp_pkg::RootW-1:0] root;
  sqrt_side_t                 sqsb_q [SqrtLat];

  spgp_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .x_i    (sum6_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqsb_q[0] <= sb6_q;
      for (int s = 1; s < SqrtLat; s++) sqsb_q[s] <= sqsb_q[s-1];
    end
  end

  // divider set-up: r * 2^30 + floor(root/2)
  logic [spgp_pkg::NumW-1:0]  num_q [3];
  logic [spgp_pkg::RootW-1:0] den_q;
  side_t                      dvsb_q [DivLat+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= (spgp_pkg::NumW'(sqsb_q[SqrtLat-1].r[i]) << spgp_pkg::FracW)
                  + spgp_pkg::NumW'(root >> 1);
      end
      den_q     <= root;
      dvsb_q[0] <= sqsb_q[SqrtLat-1].side;
      for (int s = 1; s <= DivLat; s++) dvsb_q[s] <= dvsb_q[s-1];
    end
  end

  logic [spgp_pkg::QW-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    spgp_divider u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .num_i (num_q[i]),
      .den_i (den_q),
      .quo_o (quo[i])
    );
  end

  // result assembly
  spgp_pkg::out_t res_c;
  side_t          side_end;
  logic [31:0]    pt_c [3];

  assign side_end = dvsb_q[DivLat];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (side_end.zero) pt_c[i] = '0;
      else if (side_end.neg[i]) pt_c[i] = 32'(0) - 32'(quo[i]);
      else pt_c[i] = 32'(quo[i]);
    end
    res_c.point_x     = pt_c[0];
    res_c.point_y     = pt_c[1];
    res_c.point_z     = pt_c[2];
    res_c.mesh_offset = side_end.offset;
    res_c.zero_length = side_end.zero;
  end

  // output register and skid slot
  spgp_pkg::out_t out_q, skid_q;
  logic           incoming, take;

  assign incoming = en && pipe_v_q[PipeLat-1];
  assign take     = out_v_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      if (!out_v_q || take) begin
        out_v_q  <= skid_v_q || incoming;
        skid_v_q <= 1'b0;
      end else if (incoming) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || take) begin
      out_q <= skid_v_q ? skid_q : res_c;
    end else if (incoming) begin
      skid_q <= res_c;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  a_skid_needs_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid slot holds a beat while the output register is empty");

  a_zero_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_length |->
      out_data_o.point_x == '0 && out_data_o.point_y == '0 && out_data_o.point_z == '0)
    else $error("zero-length point has non-zero components");

  a_unit_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_data_o.point_x <= 32'sh4000_0000 && out_data_o.point_x >= -32'sh4000_0000 &&
      out_data_o.point_y <= 32'sh4000_0000 && out_data_o.point_y >= -32'sh4000_0000 &&
      out_data_o.point_z <= 32'sh4000_0000 && out_data_o.point_z >= -32'sh4000_0000)
    else $error("normalised component outside unit range");

endmodule
